>>> rtl/core/hard_link_seen_table_core_assert.svh
// Assertion macros for the hard-link seen table checker.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef HARD_LINK_SEEN_TABLE_CORE_ASSERT_SVH
`define HARD_LINK_SEEN_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HLST_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hlst check failed");

// Next-cycle implication, disabled during reset
`define HLST_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hlst check failed");

`endif

>>> rtl/core/hlst_pkg.sv
// Shared types and constants for the hard-link seen table.
// No dependencies; imported by the cell, the chain and the top level.
`default_nettype none

package hlst_pkg;

   // Default table depth (number of cells)
   localparam int unsigned HLST_ENTRIES = 256;

   localparam int unsigned DEV_W   = 32;
   localparam int unsigned INO_W   = 64;
   localparam int unsigned LINKS_W = 16;

   // Lookup token walking down the cell chain
   typedef struct packed {
      logic               vld;    // token present in this stage
      logic               live;   // link count above one: table takes part
      logic               hit;    // identity matched an earlier cell
      logic               rel;    // matching entry freed
      logic               free;   // a free cell has been found
      logic [LINKS_W-1:0] links;
      logic [INO_W-1:0]   ino;
      logic [DEV_W-1:0]   dev;
   } hlst_tok_type;

   // Insert payload broadcast to all cells
   typedef struct packed {
      logic [LINKS_W-1:0] rem;
      logic [INO_W-1:0]   ino;
      logic [DEV_W-1:0]   dev;
   } hlst_ins_type;

endpackage

`default_nettype wire

>>> rtl/core/hlst_cell.sv
// One table slot: holds an identity and its remaining link count, and
// updates the passing lookup token. Depends on hlst_pkg.
`default_nettype none

module hlst_cell
   import hlst_pkg::*;
#(
   parameter int unsigned      IDX_W = 8,
   parameter logic [IDX_W-1:0] INDEX = '0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire hlst_tok_type tok_i,
   input  wire [IDX_W-1:0]   idx_i,
   output hlst_tok_type      tok_o,
   output logic [IDX_W-1:0]  idx_o,
   input  wire logic         ins_en,
   input  wire hlst_ins_type ins_i
);

   logic               valid_ff, valid_in;
   logic [DEV_W-1:0]   dev_ff, dev_in;
   logic [INO_W-1:0]   ino_ff, ino_in;
   logic [LINKS_W-1:0] rem_ff, rem_in;
   hlst_tok_type       tok_ff, tok_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               match;

   // compare, decrement or release, note first free slot, take inserts
   always_comb begin
      tok_in   = tok_i;
      idx_in   = idx_i;
      valid_in = valid_ff;
      dev_in   = dev_ff;
      ino_in   = ino_ff;
      rem_in   = rem_ff;
      match    = tok_i.vld && tok_i.live && !tok_i.hit && valid_ff &&
                 (dev_ff == tok_i.dev) && (ino_ff == tok_i.ino);
      if (match) begin
         tok_in.hit = 1'b1;
         if (rem_ff <= 16'd1) begin
            tok_in.rel = 1'b1;
            valid_in   = 1'b0;
         end else begin
            rem_in = rem_ff - 16'd1;
         end
      end
      if (tok_i.vld && tok_i.live && !valid_ff && !tok_i.free) begin
         tok_in.free = 1'b1;
         idx_in      = INDEX;
      end
      if (ins_en) begin
         valid_in = 1'b1;
         dev_in   = ins_i.dev;
         ino_in   = ins_i.ino;
         rem_in   = ins_i.rem;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      dev_ff <= dev_in;
      ino_ff <= ino_in;
      rem_ff <= rem_in;
      idx_ff <= idx_in;
   end

   assign tok_o = tok_ff;
   assign idx_o = idx_ff;

endmodule

`default_nettype wire

>>> rtl/core/hlst_chain.sv
// Row of table cells; the lookup token moves one cell per cycle, and the
// insert index is decoded to one cell. Depends on hlst_pkg and hlst_cell.
`default_nettype none

module hlst_chain
   import hlst_pkg::*;
#(
   parameter int unsigned ENTRIES = HLST_ENTRIES,
   parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire hlst_tok_type tok_i,
   output hlst_tok_type      tok_o,
   output logic [IDX_W-1:0]  idx_o,
   input  wire logic         ins_vld,
   input  wire [IDX_W-1:0]   ins_idx,
   input  wire hlst_ins_type ins_i
);

   hlst_tok_type     tok_link [0:ENTRIES];
   logic [IDX_W-1:0] idx_link [0:ENTRIES];

   assign tok_link[0] = tok_i;
   assign idx_link[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic ins_en;

      // one-hot insert select
      assign ins_en = ins_vld && (ins_idx == IDX_W'(i));

      hlst_cell #(
         .IDX_W (IDX_W),
         .INDEX (IDX_W'(i))
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_i  (tok_link[i]),
         .idx_i  (idx_link[i]),
         .tok_o  (tok_link[i+1]),
         .idx_o  (idx_link[i+1]),
         .ins_en (ins_en),
         .ins_i  (ins_i)
      );
   end

   assign tok_o = tok_link[ENTRIES];
   assign idx_o = idx_link[ENTRIES];

endmodule

`default_nettype wire

>>> rtl/core/hard_link_seen_table_core.sv
// Hard-link seen table top level: stream ports, sequencer, stop flag.
// Depends on hlst_pkg and hlst_chain.
//
//   port group   dir   beat contents
//   req_*        in    file identity: device, inode, link count
//   rsp_*        out   seen / released / stopped flags, one beat per request
//
// One request at a time: the lookup token walks the ENTRIES cells, one per
// cycle; a new request is accepted once the result is in the output register.
// The insert of a missed identity lands in the chosen cell as the token leaves
// the chain. Results wait in the output register without holding up the next
// request. Synchronous reset clears all valid bits and the stop flag at once.
`default_nettype none

module hard_link_seen_table_core
   import hlst_pkg::*;
#(
   parameter int unsigned ENTRIES = HLST_ENTRIES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [111:0]  req_tdata,   // device_id, inode_number, link_count
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata    // already_seen, entry_released,
                                           // tracking_stopped, zero pad
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             stop_ff, stop_in;
   logic [2:0]       hold_ff, hold_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [2:0]       rsp_data_ff, rsp_data_in;
   hlst_tok_type     tok_entry, tok_exit;
   logic [IDX_W-1:0] idx_exit;
   logic             ins_vld;
   hlst_ins_type     ins;
   logic             req_beat;
   logic             miss;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;

   // token into the first cell
   always_comb begin
      tok_entry.vld   = req_beat;
      tok_entry.live  = (req_tdata[111:96] > 16'd1);
      tok_entry.hit   = 1'b0;
      tok_entry.rel   = 1'b0;
      tok_entry.free  = 1'b0;
      tok_entry.links = req_tdata[111:96];
      tok_entry.ino   = req_tdata[95:32];
      tok_entry.dev   = req_tdata[31:0];
   end

   hlst_chain #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .tok_i   (tok_entry),
      .tok_o   (tok_exit),
      .idx_o   (idx_exit),
      .ins_vld (ins_vld),
      .ins_idx (idx_exit),
      .ins_i   (ins)
   );

   // commit of the exiting token: insert or stop
   assign miss      = tok_exit.vld && tok_exit.live && !tok_exit.hit && !stop_ff;
   assign ins_vld   = (state_ff == ST_SCAN) && miss && tok_exit.free;
   assign ins.dev   = tok_exit.dev;
   assign ins.ino   = tok_exit.ino;
   assign ins.rem   = tok_exit.links - 16'd1;

   // sequencer and output register
   always_comb begin
      state_in    = state_ff;
      stop_in     = stop_ff;
      hold_in     = hold_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_exit.vld) begin
               stop_in  = stop_ff || (miss && !tok_exit.free);
               hold_in  = {stop_in, tok_exit.rel, tok_exit.hit};
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = hold_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         stop_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         stop_ff    <= stop_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff};

endmodule

`default_nettype wire

>>> rtl/core/hlst_checker.sv
// Port-level checks for the hard-link seen table, bound to the top level.
// Depends on hard_link_seen_table_core_assert.svh.
`default_nettype none

`include "hard_link_seen_table_core_assert.svh"

module hlst_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_tvalid,
   input wire logic          req_tready,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [7:0]    rsp_tdata
);

   logic       req_beat, rsp_beat;
   logic [1:0] count_ff, count_in;
   logic       stop_seen_ff;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // requests accepted but not yet answered
   always_comb begin
      count_in = count_ff;
      if (req_beat && !rsp_beat) begin
         count_in = count_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 2'd0;
         stop_seen_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         stop_seen_ff <= stop_seen_ff || (rsp_beat && rsp_tdata[2]);
      end
   end

   `HLST_ASSERT_IMP(a_release_needs_seen, rsp_tvalid && rsp_tdata[1], rsp_tdata[0])
   `HLST_ASSERT_IMP(a_stop_sticky, rsp_tvalid && stop_seen_ff, rsp_tdata[2])
   `HLST_ASSERT_IMP(a_no_orphan_beat, rsp_tvalid, count_ff != 2'd0)
   `HLST_ASSERT_IMP(a_depth_limit, count_ff == 2'd2, !req_tready)
   `HLST_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind hard_link_seen_table_core hlst_checker u_hlst_checker (.*);

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the hard-link seen table (hard_link_seen_table_core).
// Depends on hlst_pkg for field widths and the table depth; drives the req_/rsp_
// streams with random idling and checks each response beat against a local predictor or a directed row's flags.

module testbench;
   import hlst_pkg::*;

   localparam int unsigned TABLE_DEPTH = HLST_ENTRIES;
   localparam int DIR_ROWS       = 21;
   localparam int CHURN_ITEMS    = 650;
   localparam int RANDOM_ITEMS   = 1550;
   localparam int POOL_SIZE      = 24;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int TIMEOUT_CYCLES = 6000000;

   // Response flags, seen in bit 0 as on rsp_tdata
   typedef struct packed {
      logic stopped;
      logic released;
      logic seen;
   } link_flags_type;

   localparam link_flags_type FL_NONE     = 3'b000;
   localparam link_flags_type FL_SEEN     = 3'b001;
   localparam link_flags_type FL_RELEASED = 3'b011;

   typedef struct {
      logic [DEV_W-1:0] dev;
      logic [INO_W-1:0] ino;
   } file_id_type;

   typedef struct {
      logic [DEV_W-1:0]   dev;
      logic [INO_W-1:0]   ino;
      logic [LINKS_W-1:0] links;
      bit                 fixed;   // flags column holds the expected beat
      link_flags_type     flags;
   } stim_row_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic [111:0]  req_tdata  = '0;   // device_id, inode_number, link_count
   logic          rsp_tready = 1'b0;
   wire           req_tready;
   wire           rsp_tvalid;
   wire  [7:0]    rsp_tdata;         // already_seen, entry_released, tracking_stopped, pad

   // Predictor copy of the table
   bit                 tbl_valid     [TABLE_DEPTH];
   logic [DEV_W-1:0]   tbl_dev       [TABLE_DEPTH];
   logic [INO_W-1:0]   tbl_ino       [TABLE_DEPTH];
   logic [LINKS_W-1:0] tbl_remaining [TABLE_DEPTH];
   bit                 tbl_stopped = 1'b0;
   int                 tbl_used    = 0;

   link_flags_type expected_flags_q [$];
   link_flags_type oldest_flags;
   link_flags_type got_flags;

   stim_row_type   directed_rows [DIR_ROWS];
   file_id_type    id_pool [POOL_SIZE];
   file_id_type    filled_ids [$];

   int error_count     = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int seen_beats      = 0;
   int released_beats  = 0;

   hard_link_seen_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Table update for one identity; returns the flags the block should report
   function automatic link_flags_type track_identity(input logic [DEV_W-1:0] dev,
                                                     input logic [INO_W-1:0] ino,
                                                     input logic [LINKS_W-1:0] links);
      link_flags_type flags;
      int             hit_slot;
      int             free_slot;
      flags     = FL_NONE;
      hit_slot  = -1;
      free_slot = -1;
      if (links > 1) begin
         // associative match plus lowest free slot
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_valid[i]) begin
               if (hit_slot < 0 && tbl_dev[i] == dev && tbl_ino[i] == ino)
                  hit_slot = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit_slot >= 0) begin
            flags.seen = 1'b1;
            if (tbl_remaining[hit_slot] <= 1) begin
               tbl_remaining[hit_slot] = '0;
               tbl_valid[hit_slot]     = 1'b0;
               flags.released          = 1'b1;
               tbl_used--;
            end else begin
               tbl_remaining[hit_slot] = tbl_remaining[hit_slot] - 1'b1;
            end
         end else if (!tbl_stopped) begin
            if (free_slot < 0) begin
               tbl_stopped = 1'b1;
            end else begin
               tbl_valid[free_slot]     = 1'b1;
               tbl_dev[free_slot]       = dev;
               tbl_ino[free_slot]       = ino;
               tbl_remaining[free_slot] = links - 1'b1;
               tbl_used++;
            end
         end
      end
      flags.stopped = tbl_stopped;
      return flags;
   endfunction

   // Drive one request beat from a falling edge, wait for accept, then idle for a random gap, often none.
   // Returns at a falling edge.
   task automatic send_identity(input logic [DEV_W-1:0] dev, input logic [INO_W-1:0] ino,
                                input logic [LINKS_W-1:0] links, input bit fixed,
                                input link_flags_type fixed_flags);
      link_flags_type predicted;
      int             pick;
      int             gap;
      req_tdata  = {links, ino, dev};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = track_identity(dev, ino, links);
      expected_flags_q.push_back(fixed ? fixed_flags : predicted);
      items_sent++;
      @(negedge clock);
      // mostly back to back, sometimes short gaps, rarely long ones
      pick = $urandom_range(0, 99);
      if (pick < 70)      gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 10);
      else                gap = $urandom_range(11, 300);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_flags = rsp_tdata[2:0];
         if (got_flags.seen)     seen_beats++;
         if (got_flags.released) released_beats++;
         if (expected_flags_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR: response beat %b with nothing expected", got_flags);
         end else begin
            oldest_flags = expected_flags_q.pop_front();
            results_checked++;
            if (got_flags.seen != oldest_flags.seen ||
                got_flags.released != oldest_flags.released ||
                got_flags.stopped != oldest_flags.stopped) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("ERROR: beat %0d seen/released/stopped expected %b/%b/%b got %b/%b/%b",
                           results_checked, oldest_flags.seen, oldest_flags.released,
                           oldest_flags.stopped, got_flags.seen, got_flags.released,
                           got_flags.stopped);
            end
         end
      end
   end

   // Response back-pressure: open stretches, short stalls, rare long stalls
   initial begin : rsp_stall_gen
      int pick;
      @(negedge reset);
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(1, 600)) @(negedge clock);
         end else begin
            rsp_tready = 1'b0;
            if (pick < 90) repeat ($urandom_range(1, 8)) @(negedge clock);
            else           repeat ($urandom_range(50, 400)) @(negedge clock);
            rsp_tready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * 4);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int          random_sent;
      int          pick;
      int          drain_cycles;
      file_id_type fid;

      // directed rows: extremes, single-link cases, partial matches, releases
      directed_rows[0]  = '{32'h0, 64'h0, 16'd0, 1'b1, FL_NONE};
      directed_rows[1]  = '{32'h0, 64'h0, 16'd1, 1'b1, FL_NONE};
      directed_rows[2]  = '{32'h0, 64'h0, 16'd2, 1'b1, FL_NONE};
      directed_rows[3]  = '{32'h0, 64'h0, 16'd1, 1'b1, FL_NONE};      // single link, slot held
      directed_rows[4]  = '{32'h0, 64'h0, 16'd0, 1'b1, FL_NONE};
      directed_rows[5]  = '{32'h0, 64'h0, 16'd2, 1'b1, FL_RELEASED};
      directed_rows[6]  = '{32'h0, 64'h0, 16'd2, 1'b1, FL_NONE};      // reinsert freed id
      directed_rows[7]  = '{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, FL_NONE};
      directed_rows[8]  = '{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd2, 1'b1, FL_SEEN};
      directed_rows[9]  = '{32'hFFFF_FFFF, 64'h0, 16'd3, 1'b1, FL_NONE}; // device matches only
      directed_rows[10] = '{32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd3, 1'b1, FL_NONE}; // inode only
      directed_rows[11] = '{32'h0, 64'h0, 16'hFFFF, 1'b1, FL_RELEASED};
      directed_rows[12] = '{32'hFFFF_FFFF, 64'h0, 16'd9, 1'b1, FL_SEEN};
      directed_rows[13] = '{32'hFFFF_FFFF, 64'h0, 16'd9, 1'b1, FL_RELEASED};
      directed_rows[14] = '{32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd2, 1'b1, FL_SEEN};
      directed_rows[15] = '{32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd2, 1'b1, FL_RELEASED};
      directed_rows[16] = '{32'h1, 64'h1, 16'd3, 1'b0, FL_NONE};
      directed_rows[17] = '{32'h1, 64'h1, 16'd3, 1'b0, FL_NONE};
      directed_rows[18] = '{32'h1, 64'h1, 16'd3, 1'b0, FL_NONE};
      directed_rows[19] = '{32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 16'h8000, 1'b0, FL_NONE};
      directed_rows[20] = '{32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 16'h7FFF, 1'b0, FL_NONE};

      // working set, with some pairs sharing device or inode
      for (int k = 0; k < POOL_SIZE; k++) begin
         id_pool[k].dev = $urandom;
         id_pool[k].ino = {$urandom, $urandom};
         if (k % 4 == 1) id_pool[k].dev = id_pool[k-1].dev;
         if (k % 4 == 2) id_pool[k].ino = id_pool[k-1].ino;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIR_ROWS; r++)
         send_identity(directed_rows[r].dev, directed_rows[r].ino, directed_rows[r].links,
                       directed_rows[r].fixed, directed_rows[r].flags);

      // churn on the working set: inserts, hits and releases
      random_sent = 0;
      while (random_sent < CHURN_ITEMS) begin
         pick = $urandom_range(0, 99);
         fid  = id_pool[$urandom_range(0, POOL_SIZE-1)];
         if (pick < 75)
            send_identity(fid.dev, fid.ino, LINKS_W'($urandom_range(2, 6)), 1'b0, FL_NONE);
         else if (pick < 87)
            send_identity(fid.dev, fid.ino, LINKS_W'($urandom_range(0, 1)), 1'b0, FL_NONE);
         else
            send_identity($urandom, {$urandom, $urandom}, LINKS_W'($urandom_range(0, 65535)),
                          1'b0, FL_NONE);
         random_sent++;
      end

      // fill every free slot with long-lived entries, then miss on a full table
      while (tbl_used < TABLE_DEPTH) begin
         fid.dev = $urandom;
         fid.ino = {$urandom, $urandom};
         filled_ids.push_back(fid);
         send_identity(fid.dev, fid.ino, LINKS_W'($urandom_range(2, 65535)), 1'b0, FL_NONE);
         random_sent++;
      end
      repeat (3) begin
         send_identity($urandom, {$urandom, $urandom}, LINKS_W'($urandom_range(2, 65535)),
                       1'b0, FL_NONE);
         random_sent++;
      end

      // inserts stopped: hits and releases continue, misses report not seen
      while (random_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            fid = id_pool[$urandom_range(0, POOL_SIZE-1)];
            send_identity(fid.dev, fid.ino, LINKS_W'($urandom_range(2, 6)), 1'b0, FL_NONE);
         end else if (pick < 70) begin
            fid = filled_ids[$urandom_range(0, filled_ids.size()-1)];
            send_identity(fid.dev, fid.ino, LINKS_W'($urandom_range(2, 65535)), 1'b0, FL_NONE);
         end else if (pick < 80) begin
            fid = id_pool[$urandom_range(0, POOL_SIZE-1)];
            send_identity(fid.dev, fid.ino, LINKS_W'($urandom_range(0, 1)), 1'b0, FL_NONE);
         end else begin
            send_identity($urandom, {$urandom, $urandom}, LINKS_W'($urandom_range(0, 65535)),
                          1'b0, FL_NONE);
         end
         random_sent++;
      end
      req_tvalid = 1'b0;

      // drain outstanding responses, then keep watching for stray beats before the final check
      drain_cycles = 0;
      while (expected_flags_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (expected_flags_q.size() != 0) begin
         error_count += expected_flags_q.size();
         $display("ERROR: %0d expected response beats never arrived", expected_flags_q.size());
      end

      $display("Sent %0d identities, checked %0d responses (%0d seen, %0d released).",
               items_sent, results_checked, seen_beats, released_beats);
      $display("Table filled and inserts stopped: %0d; mismatches: %0d.",
               tbl_stopped, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> hard_link_seen_table_core.f
+incdir+rtl/core
rtl/core/hlst_pkg.sv
rtl/core/hlst_cell.sv
rtl/core/hlst_chain.sv
rtl/core/hard_link_seen_table_core.sv
rtl/core/hlst_checker.sv
test/testbench.sv
